### rtl/core/repeated_pulse_generator_defines.svh
// ---------------------------------------------------------------------------
// Repeated pulse generator assertion macros
// Shared property templates for the port checker.
// ---------------------------------------------------------------------------
`ifndef REPEATED_PULSE_GENERATOR_DEFINES_SVH
`define REPEATED_PULSE_GENERATOR_DEFINES_SVH

// implication checked outside reset
`define RPG_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rpg: implication violated");

// next-cycle implication checked outside reset
`define RPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rpg: next-cycle property violated");

// next-cycle implication that also holds through reset
`define RPG_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("rpg: reset property violated");

`endif

### rtl/core/rpg_pkg.sv
// ---------------------------------------------------------------------------
// Repeated pulse generator package
// Stage codes, register map and shared structs.
// ---------------------------------------------------------------------------
package rpg_pkg;

   localparam int TIME_W  = 16;
   localparam int COUNT_W = 18;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   localparam logic [1:0] STAGE_START = 2'd0;
   localparam logic [1:0] STAGE_HIGH  = 2'd1;
   localparam logic [1:0] STAGE_LOW   = 2'd2;
   localparam logic [1:0] STAGE_IDLE  = 2'd3;

   localparam logic [1:0] REG_HIGH_TIME    = 2'd0;
   localparam logic [1:0] REG_LOW_TIME     = 2'd1;
   localparam logic [1:0] REG_REPEAT_COUNT = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [TIME_W-1:0] high_time;
      logic [TIME_W-1:0] low_time;
      logic [TIME_W-1:0] repeat_count;
   } cfg_type;

   typedef struct packed {
      logic              is_load;
      logic [TIME_W-1:0] elapsed;
   } step_type;

   typedef struct packed {
      logic pin_write;
      logic pin_level;
   } result_type;

endpackage

### rtl/core/rpg_engine.sv
// ---------------------------------------------------------------------------
// Repeated pulse generator engine
// Holds the pulse train state and works out one request per cycle while step_valid is high.
// ---------------------------------------------------------------------------
module rpg_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_valid,
   input  rpg_pkg::step_type   step,
   input  rpg_pkg::cfg_type    cfg,
   output rpg_pkg::result_type result
);

   logic [1:0]                   phase_ff, phase_in;
   logic [rpg_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [rpg_pkg::TIME_W-1:0]   pulses_ff, pulses_in;
   logic                         restart_ff, restart_in;

   logic [1:0]                   phase_cur;
   logic [rpg_pkg::COUNT_W:0]    sum;
   logic [rpg_pkg::COUNT_W-1:0]  sum_sat;
   logic [rpg_pkg::TIME_W:0]     period;

   assign phase_cur = restart_ff ? rpg_pkg::STAGE_START : phase_ff;
   assign sum       = {1'b0, count_ff} + {3'b000, step.elapsed};
   assign sum_sat   = sum[rpg_pkg::COUNT_W] ? rpg_pkg::COUNT_MAX
                                            : sum[rpg_pkg::COUNT_W-1:0];
   assign period    = {1'b0, cfg.high_time} + {1'b0, cfg.low_time};

   always_comb begin
      phase_in         = phase_ff;
      count_in         = count_ff;
      pulses_in        = pulses_ff;
      restart_in       = restart_ff;
      result.pin_write = 1'b0;
      result.pin_level = 1'b0;
      if (step.is_load) begin
         pulses_in  = cfg.repeat_count;
         restart_in = 1'b1;
      end else begin
         restart_in = 1'b0;
         phase_in   = phase_cur;
         case (phase_cur)
            rpg_pkg::STAGE_START: begin
               result.pin_write = 1'b1;
               phase_in         = rpg_pkg::STAGE_IDLE;
               if (cfg.high_time != '0) begin
                  result.pin_level = 1'b1;
                  if (cfg.low_time != '0) begin
                     count_in = '0;
                     phase_in = rpg_pkg::STAGE_HIGH;
                  end
               end
            end
            rpg_pkg::STAGE_HIGH: begin
               count_in = sum_sat;
               if (sum_sat >= {2'b00, cfg.high_time}) begin
                  result.pin_write = 1'b1;
                  phase_in         = rpg_pkg::STAGE_LOW;
               end
            end
            rpg_pkg::STAGE_LOW: begin
               count_in = sum_sat;
               if (sum_sat >= {1'b0, period}) begin
                  count_in         = sum_sat - {1'b0, period};
                  result.pin_write = 1'b1;
                  if (pulses_ff == rpg_pkg::TIME_W'(1)) begin
                     phase_in = rpg_pkg::STAGE_IDLE;
                  end else begin
                     result.pin_level = 1'b1;
                     if (pulses_ff != '0) begin
                        pulses_in = pulses_ff - rpg_pkg::TIME_W'(1);
                     end
                     phase_in = rpg_pkg::STAGE_HIGH;
                  end
               end
            end
            default: begin
               phase_in = phase_cur;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= rpg_pkg::STAGE_IDLE;
         count_ff   <= '0;
         pulses_ff  <= '0;
         restart_ff <= 1'b0;
      end else if (step_valid) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         pulses_ff  <= pulses_in;
         restart_ff <= restart_in;
      end
   end

endmodule

### rtl/core/repeated_pulse_generator.sv
// A tick request is held in the input register, then its response in the output register.
// One request per cycle unless a tick request waits on a stalled response; load requests give no response.
// The pulse state update adds the elapsed time with saturation, compares and subtracts per request.
// Reset clears the pipeline, the pulse state (stage idle) and the config registers.
// ---------------------------------------------------------------------------
// Repeated pulse generator
// Pulse train generator with repeat count, tick and load requests in,
// pin write responses out, APB-style register port.
// ---------------------------------------------------------------------------
module repeated_pulse_generator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [15:0]                 req_tdata,   // elapsed[15:0]
   input  logic [0:0]                  req_tuser,   // req_type
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata,   // pin_write, pin_level, zeros
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [rpg_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [rpg_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [rpg_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);

   rpg_pkg::cfg_type    cfg_ff;
   logic                in_valid_ff;
   rpg_pkg::step_type   in_step_ff;
   logic                out_valid_ff;
   rpg_pkg::result_type out_result_ff;
   rpg_pkg::result_type result;
   logic                out_free;
   logic                process;
   logic                cfg_write;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign process    = in_valid_ff && (in_step_ff.is_load || out_free);
   assign req_tready = !in_valid_ff || process;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b000000, out_result_ff.pin_level, out_result_ff.pin_write};

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_paddr[3:2])
         rpg_pkg::REG_HIGH_TIME:    csr_prdata = {16'h0000, cfg_ff.high_time};
         rpg_pkg::REG_LOW_TIME:     csr_prdata = {16'h0000, cfg_ff.low_time};
         rpg_pkg::REG_REPEAT_COUNT: csr_prdata = {16'h0000, cfg_ff.repeat_count};
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (cfg_write) begin
         case (csr_paddr[3:2])
            rpg_pkg::REG_HIGH_TIME:    cfg_ff.high_time    <= csr_pwdata[15:0];
            rpg_pkg::REG_LOW_TIME:     cfg_ff.low_time     <= csr_pwdata[15:0];
            rpg_pkg::REG_REPEAT_COUNT: cfg_ff.repeat_count <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_step_ff.is_load <= req_tuser[0];
         in_step_ff.elapsed <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= process && !in_step_ff.is_load;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && process && !in_step_ff.is_load) begin
         out_result_ff <= result;
      end
   end

   rpg_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .step_valid (process),
      .step       (in_step_ff),
      .cfg        (cfg_ff),
      .result     (result)
   );

endmodule

### rtl/core/rpg_checker.sv
// ---------------------------------------------------------------------------
// Repeated pulse generator port checker
// Watches the response channel of the top level over time.
// ---------------------------------------------------------------------------
`include "repeated_pulse_generator_defines.svh"

module rpg_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   `RPG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `RPG_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `RPG_ASSERT_IMPL(a_level_needs_write, clock, reset, rsp_tvalid && rsp_tdata[1], rsp_tdata[0])
   `RPG_ASSERT_NEXT_ALWAYS(a_reset_clears_rsp, clock, reset, !rsp_tvalid)

endmodule

bind repeated_pulse_generator rpg_checker u_rpg_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
